### rtl/kpf_pkg.sv
// Package with shared widths, constants and the sequencer state type.
package kpf_pkg;
  localparam int FRAC_BITS = 40;
  localparam int VAR_W = 41;
  localparam int ANG_W = 43;
  localparam int INNOV_W = ANG_W + 1;
  localparam int GAIN_W = FRAC_BITS + 1;
  localparam int PROD_W = INNOV_W + GAIN_W;
  localparam int RES_W = PROD_W - FRAC_BITS;
  localparam int DATA_W = 64;
  localparam int NSTATE = 6;
  localparam int IDX_W = 3;
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_PROC_VAR = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEAS_VAR = 8'd1;
  localparam logic [VAR_W-1:0] PROC_VAR_RST = 41'd10995116;
  localparam logic [VAR_W-1:0] MEAS_VAR_RST = 41'd2749878581;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_NEXT,
    ST_WAIT,
    ST_READ
  } seq_state_t;
endpackage

### rtl/kpf_gain_div.sv
// Bit-serial divider that forms the scalar gain q * 2^FRAC_BITS / (q + r).
module kpf_gain_div import kpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VAR_W-1:0]  q,
  input  logic [VAR_W-1:0]  r,
  output logic              done,
  output logic [GAIN_W-1:0] gain
);
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic [VAR_W:0]    rem_r, rem_nxt;
  logic [VAR_W:0]    div_r, div_nxt;
  logic [GAIN_W-1:0] k_r, k_nxt;
  logic              zero_r, zero_nxt;
  logic [VAR_W:0]    sum;
  logic [VAR_W+1:0]  rem2;
  logic              ge;

  always_comb begin
    sum = {1'b0, q} + {1'b0, r};
    rem2 = {rem_r, 1'b0};
    ge = rem2 >= {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    div_nxt = div_r;
    k_nxt = k_r;
    zero_nxt = zero_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      div_nxt = sum;
      zero_nxt = (sum == '0);
      if ({1'b0, q} >= sum) begin
        rem_nxt = {1'b0, q} - sum;
        k_nxt = GAIN_W'(1);
      end else begin
        rem_nxt = {1'b0, q};
        k_nxt = '0;
      end
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = (VAR_W+1)'(rem2 - {1'b0, div_r});
      end else begin
        rem_nxt = rem2[VAR_W:0];
      end
      k_nxt = {k_r[GAIN_W-2:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(FRAC_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    k_r <= k_nxt;
    zero_r <= zero_nxt;
  end

  assign done = done_r;
  assign gain = zero_r ? '0 : k_r;
endmodule

### rtl/kpf_mul.sv
// Shift-add multiplier that scales a signed innovation by the gain and floors.
module kpf_mul import kpf_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [INNOV_W-1:0] a,
  input  logic [GAIN_W-1:0]        b,
  output logic                     done,
  output logic signed [RES_W-1:0]  p
);
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;
  logic [5:0]               cnt_r, cnt_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic signed [PROD_W-1:0] sh_r, sh_nxt;
  logic [GAIN_W-1:0]        b_r, b_nxt;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    sh_nxt = sh_r;
    b_nxt = b_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = '0;
      acc_nxt = '0;
      sh_nxt = PROD_W'(a);
      b_nxt = b;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_nxt = acc_r + sh_r;
      end
      sh_nxt = sh_r <<< 1;
      b_nxt = b_r >> 1;
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(GAIN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    sh_r <= sh_nxt;
    b_r <= b_nxt;
  end

  assign done = done_r;
  assign p = acc_r[PROD_W-1:FRAC_BITS];
endmodule

### rtl/kalman_pose_fusion_6state.sv
// Top level of the six-state pose fusion filter with its estimate memory.
// Usage:
// The input channel (in_valid/in_ready) takes one fusion tick: odometry pose
// and inertial angles. The result channel (out_valid/out_ready) returns the
// six fused estimates of that tick. The configuration channel (cfg_valid,
// cfg_ready, cfg_index, cfg_data) writes the process variance (index 0) and
// the measurement variance (index 1); it is always ready.
// A tick runs the gain divider and one shift-add multiply for each angle,
// then reads the six estimates from memory.
// One item is in work at a time; a new transfer is taken once the previous
// item has reached the output register, even while that result still waits.
// If the receiver stalls, the result holds on the output ports and the
// next item waits before its readout until the output register is free.
// Reset, synchronous and active low, restores the default variances and
// clears all handshake state.
module kalman_pose_fusion_6state import kpf_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [DATA_W-1:0]  in_odom_x,
  input  logic signed [DATA_W-1:0]  in_odom_y,
  input  logic signed [DATA_W-1:0]  in_odom_z,
  input  logic signed [ANG_W-1:0]   in_odom_roll,
  input  logic signed [ANG_W-1:0]   in_odom_pitch,
  input  logic signed [ANG_W-1:0]   in_odom_yaw,
  input  logic signed [ANG_W-1:0]   in_imu_roll,
  input  logic signed [ANG_W-1:0]   in_imu_pitch,
  input  logic signed [ANG_W-1:0]   in_imu_yaw,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  out_est_x,
  output logic signed [DATA_W-1:0]  out_est_y,
  output logic signed [DATA_W-1:0]  out_est_z,
  output logic signed [DATA_W-1:0]  out_est_roll,
  output logic signed [DATA_W-1:0]  out_est_pitch,
  output logic signed [DATA_W-1:0]  out_est_yaw,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [VAR_W-1:0]          cfg_data
);
  seq_state_t state_r, state_nxt;
  logic [VAR_W-1:0]  q_r, r_r;
  logic [DATA_W-1:0] pos_r [3];
  logic [ANG_W-1:0]  oang_r [3];
  logic [ANG_W-1:0]  iang_r [3];
  logic [DATA_W-1:0] est_mem [NSTATE];
  logic [DATA_W-1:0] rd_data_r;
  logic [DATA_W-1:0] out_r [NSTATE];
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic              div_start, div_done, mul_start, mul_done;
  logic [GAIN_W-1:0] gain;
  logic signed [INNOV_W-1:0] innov;
  logic signed [RES_W-1:0]   mprod;
  logic              we;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [DATA_W-1:0] wdata;
  logic              cap;
  logic [1:0]        aidx;

  assign cfg_ready = 1'b1;
  assign in_ready = (state_r == ST_IDLE);
  assign aidx = (state_r == ST_DIV) ? 2'd0 : cnt_r[1:0];
  assign innov = INNOV_W'($signed(iang_r[aidx])) - INNOV_W'($signed(oang_r[aidx]));

  kpf_gain_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .q(q_r), .r(r_r),
    .done(div_done), .gain(gain)
  );

  kpf_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start), .a(innov), .b(gain),
    .done(mul_done), .p(mprod)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    out_valid_nxt = out_valid_r;
    div_start = 1'b0;
    mul_start = 1'b0;
    we = 1'b0;
    waddr = cnt_r;
    wdata = pos_r[cnt_r[1:0]];
    raddr = cnt_r;
    cap = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          div_start = 1'b1;
          cnt_nxt = '0;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r < IDX_W'(3)) begin
          we = 1'b1;
          cnt_nxt = cnt_r + IDX_W'(1);
        end
        if (div_done) begin
          cnt_nxt = '0;
          mul_start = 1'b1;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        if (mul_done) begin
          we = 1'b1;
          waddr = cnt_r + IDX_W'(3);
          wdata = DATA_W'($signed(oang_r[aidx])) + DATA_W'(mprod);
          if (cnt_r == IDX_W'(2)) begin
            cnt_nxt = '0;
            state_nxt = ST_WAIT;
          end else begin
            cnt_nxt = cnt_r + IDX_W'(1);
            state_nxt = ST_NEXT;
          end
        end
      end
      ST_NEXT: begin
        mul_start = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_WAIT: begin
        if (!out_valid_r) begin
          cnt_nxt = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        if (cnt_r != '0) begin
          cap = 1'b1;
        end
        if (cnt_r == IDX_W'(NSTATE)) begin
          out_valid_nxt = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      q_r <= PROC_VAR_RST;
      r_r <= MEAS_VAR_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_index == REG_PROC_VAR) begin
        q_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == REG_MEAS_VAR) begin
        r_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pos_r[0] <= in_odom_x;
      pos_r[1] <= in_odom_y;
      pos_r[2] <= in_odom_z;
      oang_r[0] <= in_odom_roll;
      oang_r[1] <= in_odom_pitch;
      oang_r[2] <= in_odom_yaw;
      iang_r[0] <= in_imu_roll;
      iang_r[1] <= in_imu_pitch;
      iang_r[2] <= in_imu_yaw;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      est_mem[waddr] <= wdata;
    end
    rd_data_r <= est_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cap) begin
      out_r[cnt_r - IDX_W'(1)] <= rd_data_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_est_x = out_r[0];
  assign out_est_y = out_r[1];
  assign out_est_z = out_r[2];
  assign out_est_roll = out_r[3];
  assign out_est_pitch = out_r[4];
  assign out_est_yaw = out_r[5];
endmodule
